>>> hw/rtl/sequential_sample_skip_assert.svh
// Assertion macros for the sample skip generator
`ifndef SEQUENTIAL_SAMPLE_SKIP_ASSERT_SVH
`define SEQUENTIAL_SAMPLE_SKIP_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define SSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> hw/rtl/sss_pkg.sv
// Shared codes for the sample skip generator
`timescale 1ns / 1ps
package sss_pkg;
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd2;
    localparam logic       CMD_DRAW        = 1'b0;
    localparam logic       CMD_RESTART     = 1'b1;
    localparam logic [0:0] REG_POPULATION  = 1'd0;
    localparam logic [0:0] REG_SAMPLE      = 1'd1;
endpackage

>>> hw/rtl/sss_divider.sv
// Bit-serial restoring divider: quo = floor(num * 2^FRAC_BITS / den), num < den
`timescale 1ns / 1ps
module sss_divider #(
    parameter int COUNT_BITS = 32,
    parameter int FRAC_BITS  = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] num,
    input  logic [COUNT_BITS-1:0] den,
    output logic                  done,
    output logic [FRAC_BITS:0]    quo
);
    localparam int CW = $clog2(FRAC_BITS + 1);

    logic [COUNT_BITS:0]   rem_reg;
    logic [COUNT_BITS-1:0] den_reg;
    logic [FRAC_BITS:0]    quo_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [COUNT_BITS:0]   shifted;
    logic                  take;

    // One quotient bit per cycle
    assign shifted = {rem_reg[COUNT_BITS-1:0], 1'b0};
    assign take    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(FRAC_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? shifted - {1'b0, den_reg} : shifted;
            quo_reg <= {quo_reg[FRAC_BITS-1:0], take};
        end
    end

    // A zero record count gives a zero ratio
    assign done = done_reg;
    assign quo  = (den_reg == '0) ? '0 : quo_reg;
endmodule

>>> hw/rtl/sss_multiplier.sv
// Shift-add multiplier: prod = floor(a * b / 2^SHIFT), one bit of b per cycle
`timescale 1ns / 1ps
module sss_multiplier #(
    parameter int A_BITS = 33,
    parameter int B_BITS = 33,
    parameter int SHIFT  = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [A_BITS-1:0]        a,
    input  logic [B_BITS-1:0]        b,
    output logic                     done,
    output logic [A_BITS+B_BITS-1:0] prod
);
    localparam int PW = A_BITS + B_BITS;
    localparam int CW = $clog2(B_BITS + 1);

    logic [PW-1:0]     acc_reg;
    logic [A_BITS-1:0] a_reg;
    logic [B_BITS-1:0] b_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [PW-1:0]     sum;

    // Add the multiplicand at the top, then shift the sum down a bit
    assign sum = acc_reg + (b_reg[0] ? {a_reg, {B_BITS{1'b0}}} : '0);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(B_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            // sum fits in PW bits while a is below 2^(A_BITS-1), since acc < a*2^B
            acc_reg <= {1'b0, sum[PW-1:1]};
            b_reg   <= {1'b0, b_reg[B_BITS-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg >> SHIFT;
endmodule

>>> hw/rtl/sequential_sample_skip.sv
// Top level of the sequential sampling skip generator
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------
//  in       | in_valid / in_stall | cmd, rand_fraction
//  out      | out_valid/ out_stall| skip, last_sample, status
//  config   | APB psel/penable    | population_size, sample_size
//
// One request at a time. Restart and error requests go straight to the output
// state; the last sample is scaled in the shift-add multiplier; other draws run
// the divider for the first ratio, then the divider and the multiplier for
// each skip counted.
// Reset clears the counts and loads both registers with 1.
// The result waits in the output register while out_stall is high.
`timescale 1ns / 1ps
module sequential_sample_skip #(
    parameter int COUNT_BITS = 32,
    parameter int FRAC_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [31:0] rand_fraction,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] skip,
    output logic        last_sample,
    output logic [1:0]  status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sss_pkg::*;

    localparam int QW = FRAC_BITS + 1;
    localparam int MA = (QW > COUNT_BITS) ? QW : COUNT_BITS + 1;
    localparam int MB = (QW > 32) ? QW : 32;
    localparam int PW = MA + MB;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LAST, ST_DIV, ST_MUL, ST_TEST, ST_OUT
    } state_t;

    state_t                state_reg;
    logic [31:0]           pop_reg, samp_reg;
    logic [COUNT_BITS-1:0] rec_reg, smp_reg, top_reg;
    logic [QW-1:0]         q_reg, vf_reg;
    logic [31:0]           skip_reg;
    logic                  last_reg, out_valid_reg;
    logic [1:0]            status_reg;
    logic                  first_reg;

    logic                  div_start, div_done, mul_start, mul_done;
    logic [QW-1:0]         div_quo;
    logic [MA-1:0]         mul_a;
    logic [MB-1:0]         mul_b;
    logic [PW-1:0]         mul_prod;
    logic                  wr_en, accept;
    logic [QW-1:0]         vf_conv;

    // Register port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    always_comb begin
        case (paddr[2])
            REG_POPULATION: prdata = pop_reg;
            REG_SAMPLE:     prdata = samp_reg;
            default:        prdata = '0;
        endcase
    end
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            pop_reg  <= 32'd1;
            samp_reg <= 32'd1;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == REG_POPULATION)
                pop_reg <= pwdata;
            else
                samp_reg <= pwdata;
        end
    end

    // V aligned to FRAC_BITS
    generate
        if (FRAC_BITS >= 32) begin : g_vwide
            assign vf_conv = QW'(rand_fraction) << (FRAC_BITS - 32);
        end else begin : g_vnarrow
            assign vf_conv = QW'(rand_fraction >> (32 - FRAC_BITS));
        end
    endgenerate

    assign in_stall = (state_reg != ST_IDLE) || out_valid_reg;
    assign accept   = in_valid && !in_stall;

    assign div_start = (state_reg == ST_IDLE && accept && cmd == CMD_DRAW
                        && smp_reg > COUNT_BITS'(1))
                    || (state_reg == ST_TEST && q_reg > vf_reg);
    assign mul_start = (state_reg == ST_IDLE && accept && cmd == CMD_DRAW
                        && smp_reg == COUNT_BITS'(1))
                    || (state_reg == ST_DIV && div_done && !first_reg);
    assign mul_a = (state_reg == ST_IDLE) ? MA'(rec_reg) : MA'(q_reg);
    assign mul_b = (state_reg == ST_IDLE) ? MB'(rand_fraction) : MB'(div_quo);

    sss_divider #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(state_reg == ST_IDLE
             ? ((rec_reg > smp_reg) ? rec_reg - smp_reg : '0)
             : top_reg - 1'b1),
        .den(state_reg == ST_IDLE ? rec_reg : rec_reg - 1'b1),
        .done(div_done), .quo(div_quo)
    );

    // Full product; each use takes its own scaling
    sss_multiplier #(.A_BITS(MA), .B_BITS(MB), .SHIFT(0)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .prod(mul_prod)
    );

    // Sequencer
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rec_reg       <= '0;
            smp_reg       <= '0;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
            top_reg       <= '0;
            q_reg         <= '0;
            vf_reg        <= '0;
            skip_reg      <= '0;
            last_reg      <= 1'b0;
            status_reg    <= STATUS_OK;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        skip_reg   <= '0;
                        last_reg   <= 1'b0;
                        status_reg <= STATUS_OK;
                        if (cmd == CMD_RESTART)
                        begin
                            if (samp_reg > pop_reg)
                            begin
                                rec_reg    <= '0;
                                smp_reg    <= '0;
                                status_reg <= STATUS_BAD_SIZE;
                            end
                            else
                            begin
                                rec_reg <= COUNT_BITS'(pop_reg);
                                smp_reg <= COUNT_BITS'(samp_reg);
                            end
                            state_reg <= ST_OUT;
                        end
                        else if (smp_reg == '0)
                        begin
                            status_reg <= STATUS_EMPTY;
                            state_reg  <= ST_OUT;
                        end
                        else if (smp_reg == COUNT_BITS'(1))
                            state_reg <= ST_LAST;
                        else
                        begin
                            vf_reg    <= vf_conv;
                            top_reg   <= (rec_reg > smp_reg) ? rec_reg - smp_reg : '0;
                            first_reg <= 1'b1;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_LAST:
                begin
                    if (mul_done)
                    begin
                        skip_reg <= mul_prod[63:32];
                        last_reg <= 1'b1;
                        smp_reg  <= '0;
                        if (rec_reg != '0)
                            rec_reg <= rec_reg - 1'b1;
                        state_reg <= ST_OUT;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        if (first_reg)
                        begin
                            q_reg     <= div_quo;
                            first_reg <= 1'b0;
                            state_reg <= ST_TEST;
                        end
                        else
                            state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (mul_done)
                    begin
                        q_reg     <= mul_prod[FRAC_BITS +: QW];
                        state_reg <= ST_TEST;
                    end
                end
                ST_TEST:
                begin
                    if (q_reg > vf_reg)
                    begin
                        // count a skip; divider already started on the new ratio
                        skip_reg  <= skip_reg + 1'b1;
                        top_reg   <= top_reg - 1'b1;
                        rec_reg   <= rec_reg - 1'b1;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        rec_reg   <= rec_reg - 1'b1;
                        smp_reg   <= smp_reg - 1'b1;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign skip        = skip_reg;
    assign last_sample = last_reg;
    assign status      = status_reg;

`include "sequential_sample_skip_assert.svh"
    `SSS_ASSERT_IMP(a_one_request, out_valid_reg, state_reg == ST_IDLE, "busy with result held")
    `SSS_ASSERT_IMP(a_last_ok, out_valid && last_sample, status == STATUS_OK, "last with error")
    `SSS_ASSERT_IMP(a_err_noskip, out_valid && status != STATUS_OK, skip == '0, "skip on error")
    `SSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(skip), "result lost")
endmodule
